// ===== rtl/rcsf_pkg.sv =====
// Shared types, constants and the well-known size lookup of the resolution change score filter.
package rcsf_pkg;

  localparam int unsigned DIM_W       = 12;
  localparam int unsigned SCORE_W     = 8;
  localparam int unsigned SLOT_IDX_W  = 5;
  localparam int unsigned SLOT_OUT_W  = 3;
  localparam int unsigned CFG_IDX_W   = 4;
  localparam int unsigned CFG_DATA_W  = 12;
  localparam int unsigned DEF_SLOTS   = 8;
  localparam int unsigned KNOWN_COUNT = 22;

  localparam logic [SCORE_W-1:0] SCORE_MAX    = 8'd200;
  localparam logic [SCORE_W-1:0] REPEAT_BONUS = 8'd50;
  localparam logic [SCORE_W-1:0] SINGLE_BONUS = 8'd1;
  localparam logic [SCORE_W-1:0] MIN_START    = 8'hFF;

  localparam logic [DIM_W-1:0] KEY_WIDTH_RST  = 12'd720;
  localparam logic [DIM_W-1:0] KEY_HEIGHT_RST = 12'd576;

  localparam logic [CFG_IDX_W-1:0] REG_KEY_WIDTH  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_HEIGHT = 4'd1;

  typedef enum logic [1:0] {
    VERDICT_SAME    = 2'd0,
    VERDICT_DIFFERS = 2'd1,
    VERDICT_KEY_ERR = 2'd2
  } verdict_e;

  typedef struct packed {
    logic [DIM_W-1:0]   width;
    logic [DIM_W-1:0]   height;
    logic [SCORE_W-1:0] score;
  } known_entry_t;

  // Running result of one frame size as it walks along the slot cells.
  typedef struct packed {
    logic                  valid;
    logic [DIM_W-1:0]      width;
    logic [DIM_W-1:0]      height;
    logic                  found;
    logic [SLOT_IDX_W-1:0] hit;
    logic [SCORE_W-1:0]    hit_score;
    logic [SCORE_W-1:0]    low_score;
    logic [SLOT_IDX_W-1:0] victim;
    logic [SCORE_W-1:0]    key_ref;
  } scan_t;

  // Table update broadcast to every cell.
  typedef struct packed {
    logic                  reload;
    logic                  we;
    logic [SLOT_IDX_W-1:0] idx;
    logic [DIM_W-1:0]      width;
    logic [DIM_W-1:0]      height;
    logic [SCORE_W-1:0]    score;
  } slot_cmd_t;

  localparam known_entry_t KNOWN_SIZES [KNOWN_COUNT] = '{
    '{12'd720,  12'd480,  8'd100}, '{12'd720,  12'd576,  8'd100},
    '{12'd1280, 12'd720,  8'd100}, '{12'd1920, 12'd1088, 8'd100},
    '{12'd1920, 12'd1080, 8'd100}, '{12'd704,  12'd576,  8'd80},
    '{12'd640,  12'd480,  8'd80},  '{12'd352,  12'd288,  8'd60},
    '{12'd352,  12'd240,  8'd60},  '{12'd540,  12'd576,  8'd60},
    '{12'd540,  12'd480,  8'd60},  '{12'd352,  12'd576,  8'd60},
    '{12'd480,  12'd576,  8'd60},  '{12'd352,  12'd480,  8'd60},
    '{12'd480,  12'd480,  8'd40},  '{12'd352,  12'd576,  8'd10},
    '{12'd352,  12'd480,  8'd10},  '{12'd480,  12'd576,  8'd10},
    '{12'd480,  12'd480,  8'd10},  '{12'd540,  12'd576,  8'd10},
    '{12'd540,  12'd480,  8'd10},  '{12'd0,    12'd0,    8'd0}
  };

  // The last matching entry wins; an unknown size scores one.
  function automatic logic [SCORE_W-1:0] known_score(input logic [DIM_W-1:0] w,
                                                     input logic [DIM_W-1:0] h);
    logic [SCORE_W-1:0] score;
    score = SINGLE_BONUS;
    for (int i = 0; i < KNOWN_COUNT; i++) begin
      if (KNOWN_SIZES[i].width == w && KNOWN_SIZES[i].height == h) begin
        score = KNOWN_SIZES[i].score;
      end
    end
    return score;
  endfunction

endpackage

// ===== rtl/rcsf_in_if.sv =====
// Input channel carrying one reported frame size per beat.
interface rcsf_in_if;
  import rcsf_pkg::*;
  logic             valid;
  logic             ready;
  logic [DIM_W-1:0] frame_width;
  logic [DIM_W-1:0] frame_height;
  modport source (output valid, output frame_width, output frame_height, input ready);
  modport sink (input valid, input frame_width, input frame_height, output ready);
endinterface

// ===== rtl/rcsf_out_if.sv =====
// Output channel carrying one verdict and slot per beat.
interface rcsf_out_if;
  import rcsf_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [1:0]            verdict;
  logic [SLOT_OUT_W-1:0] slot;
  modport source (output valid, output verdict, output slot, input ready);
  modport sink (input valid, input verdict, input slot, output ready);
endinterface

// ===== rtl/rcsf_cell.sv =====
// One table slot: holds width, height and score and folds them into the passing scan.
module rcsf_cell
  import rcsf_pkg::*;
#(
  parameter int unsigned CELL_IDX = 0
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      stall_i,
  input  scan_t     scan_i,
  output scan_t     scan_o,
  input  slot_cmd_t cmd_i
);

  localparam logic [SLOT_IDX_W-1:0] MyIdx = SLOT_IDX_W'(CELL_IDX);

  logic [DIM_W-1:0]   width_q;
  logic [DIM_W-1:0]   height_q;
  logic [SCORE_W-1:0] score_q;
  scan_t              scan_d, scan_q;

  always_comb begin
    scan_d = scan_i;
    if (scan_i.width == width_q && scan_i.height == height_q) begin
      scan_d.found     = 1'b1;
      scan_d.hit       = MyIdx;
      scan_d.hit_score = score_q;
    end
    if (score_q < scan_i.low_score) begin
      scan_d.low_score = score_q;
      scan_d.victim    = MyIdx;
    end
    if (CELL_IDX == 0) begin
      scan_d.key_ref = score_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q   <= '0;
      width_q  <= '0;
      height_q <= '0;
      score_q  <= '0;
    end else begin
      if (!stall_i) begin
        scan_q <= scan_d;
      end
      if (cmd_i.reload) begin
        // A reload clears the table and puts the key into slot zero.
        if (CELL_IDX == 0) begin
          width_q  <= cmd_i.width;
          height_q <= cmd_i.height;
          score_q  <= cmd_i.score;
        end else begin
          width_q  <= '0;
          height_q <= '0;
          score_q  <= '0;
        end
      end else if (cmd_i.we && cmd_i.idx == MyIdx) begin
        width_q  <= cmd_i.width;
        height_q <= cmd_i.height;
        score_q  <= cmd_i.score;
      end
    end
  end

  assign scan_o = scan_q;

endmodule

// ===== rtl/resolution_change_score_filter_top.sv =====
// Top level of the resolution change score filter: input stage, cell chain and decision.
//
// Each input beat carries a reported frame width and height. The size walks
// along a chain of TABLE_SLOTS cells, one cell per cycle, each cell comparing
// it against its stored size and tracking the lowest score. At the end of the
// chain the matched slot is rescored, or the first lowest-scored slot is
// replaced, and one output beat gives the verdict and the slot.
// One item is handled at a time: the size is registered at the input, then in
// each cell in turn, and a new beat is taken only after the previous one has
// been committed at the end of the chain into the output register.
// A write to either key register reloads the table in the following cycle;
// input ready is low during that cycle. After reset the key is 720 by 576 and
// the table is reloaded with it before the first beat is accepted.
// If the receiver stalls, the finished result waits in the output register
// and the next input beat is still accepted; it is held at the end of the
// chain until the output register frees up.
module resolution_change_score_filter_top
  import rcsf_pkg::*;
#(
  parameter int unsigned TABLE_SLOTS = DEF_SLOTS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  rcsf_in_if.sink               in_chan,
  rcsf_out_if.source            out_chan,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic [DIM_W-1:0]      key_width_q, key_height_q;
  logic                  reload_q;
  logic                  busy_q;
  logic [SLOT_IDX_W-1:0] last_q;
  logic [SCORE_W-1:0]    known_q;
  scan_t                 launch_q;
  scan_t                 chain [TABLE_SLOTS+1];
  slot_cmd_t             cmd;
  logic                  accept, commit, stall;
  logic                  out_valid_q;
  verdict_e              verdict_q, verdict_d;
  logic [SLOT_OUT_W-1:0] slot_q;
  logic [SLOT_IDX_W-1:0] slot_d;
  logic [SCORE_W:0]      sum;
  logic [SCORE_W-1:0]    new_score;
  scan_t                 fin;

  assign in_chan.ready = !busy_q && !reload_q;
  assign accept        = in_chan.valid && in_chan.ready;

  assign fin    = chain[TABLE_SLOTS];
  assign commit = fin.valid && (!out_valid_q || out_chan.ready);
  assign stall  = fin.valid && !commit;

  assign chain[0] = launch_q;

  for (genvar g = 0; g < TABLE_SLOTS; g++) begin : g_cell
    rcsf_cell #(
      .CELL_IDX(g)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .stall_i(stall),
      .scan_i (chain[g]),
      .scan_o (chain[g+1]),
      .cmd_i  (cmd)
    );
  end

  always_comb begin
    sum       = {1'b0, fin.hit_score} +
                {1'b0, (fin.hit == last_q) ? REPEAT_BONUS : SINGLE_BONUS};
    new_score = (sum >= {1'b0, SCORE_MAX}) ? SCORE_MAX : sum[SCORE_W-1:0];

    cmd        = '0;
    cmd.reload = reload_q;
    verdict_d  = VERDICT_DIFFERS;
    slot_d     = fin.victim;
    if (reload_q) begin
      cmd.width  = key_width_q;
      cmd.height = key_height_q;
      cmd.score  = known_score(key_width_q, key_height_q);
    end else begin
      cmd.we     = commit;
      cmd.width  = fin.width;
      cmd.height = fin.height;
      if (fin.found) begin
        slot_d    = fin.hit;
        cmd.score = new_score;
        if (fin.hit == '0) begin
          verdict_d = VERDICT_SAME;
        end else if (new_score >= fin.key_ref) begin
          verdict_d = VERDICT_KEY_ERR;
        end
      end else begin
        cmd.score = known_q;
      end
      cmd.idx = slot_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_width_q  <= KEY_WIDTH_RST;
      key_height_q <= KEY_HEIGHT_RST;
      reload_q     <= 1'b1;
      busy_q       <= 1'b0;
      last_q       <= '0;
      launch_q     <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      reload_q <= cfg_we_i && (cfg_idx_i inside {REG_KEY_WIDTH, REG_KEY_HEIGHT});
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_KEY_WIDTH: begin
            key_width_q <= cfg_data_i[DIM_W-1:0];
          end
          REG_KEY_HEIGHT: begin
            key_height_q <= cfg_data_i[DIM_W-1:0];
          end
          default: begin
          end
        endcase
      end

      launch_q.valid <= accept;
      if (accept) begin
        busy_q             <= 1'b1;
        launch_q.width     <= in_chan.frame_width;
        launch_q.height    <= in_chan.frame_height;
        launch_q.found     <= 1'b0;
        launch_q.hit       <= '0;
        launch_q.hit_score <= '0;
        launch_q.low_score <= MIN_START;
        launch_q.victim    <= '0;
        launch_q.key_ref   <= '0;
      end

      if (reload_q) begin
        last_q <= '0;
      end else if (commit) begin
        last_q <= slot_d;
        busy_q <= 1'b0;
      end

      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers without reset.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      known_q <= known_score(in_chan.frame_width, in_chan.frame_height);
    end
    if (commit) begin
      verdict_q <= verdict_d;
      slot_q    <= slot_d[SLOT_OUT_W-1:0];
    end
  end

  assign out_chan.valid   = out_valid_q;
  assign out_chan.verdict = verdict_q;
  assign out_chan.slot    = slot_q;

endmodule

// ===== tb/tb_top.sv =====
// Testbench of the resolution change score filter: directed and random frame sizes checked per beat.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rcsf_pkg::*;

  localparam int unsigned SLOTS   = DEF_SLOTS;
  localparam int unsigned LATENCY = SLOTS + 2;
  localparam int KNOWN_N = 22;

  // Index writes that no register answers to.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LOW  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HIGH = 4'd15;

  // Well-known sizes as width, height and starting score; the last match wins.
  localparam int KNOWN_SIZE [KNOWN_N][3] = '{
    '{720, 480, 100}, '{720, 576, 100}, '{1280, 720, 100}, '{1920, 1088, 100},
    '{1920, 1080, 100}, '{704, 576, 80}, '{640, 480, 80}, '{352, 288, 60},
    '{352, 240, 60}, '{540, 576, 60}, '{540, 480, 60}, '{352, 576, 60},
    '{480, 576, 60}, '{352, 480, 60}, '{480, 480, 40}, '{352, 576, 10},
    '{352, 480, 10}, '{480, 576, 10}, '{480, 480, 10}, '{540, 576, 10},
    '{540, 480, 10}, '{0, 0, 0}
  };

  typedef struct packed {
    verdict_e              verdict;
    logic [SLOT_OUT_W-1:0] slot;
  } decision_t;

  class slot_table_board;
    logic [DIM_W-1:0] key_w;
    logic [DIM_W-1:0] key_h;
    logic [DIM_W-1:0] width [SLOTS];
    logic [DIM_W-1:0] height [SLOTS];
    int unsigned      score [SLOTS];
    int unsigned      last_hit;
    decision_t        decision_q[$];
    int unsigned      errors;
    int unsigned      checked;
    int unsigned      reloads;
    int unsigned      misses;
    int unsigned      saturated;
    int unsigned      n_verdict [3];

    function new();
      key_w = KEY_WIDTH_RST;
      key_h = KEY_HEIGHT_RST;
      reload_slots();
    endfunction

    function int unsigned size_score(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h);
      int unsigned s;
      s = 1;
      for (int i = 0; i < KNOWN_N; i++) begin
        if (KNOWN_SIZE[i][0] == w && KNOWN_SIZE[i][1] == h) begin
          s = KNOWN_SIZE[i][2];
        end
      end
      return s;
    endfunction

    function void reload_slots();
      for (int i = 0; i < SLOTS; i++) begin
        width[i]  = '0;
        height[i] = '0;
        score[i]  = 0;
      end
      width[0]  = key_w;
      height[0] = key_h;
      score[0]  = size_score(key_w, key_h);
      last_hit  = 0;
      reloads++;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == REG_KEY_WIDTH) begin
        key_w = data[DIM_W-1:0];
      end else if (idx == REG_KEY_HEIGHT) begin
        key_h = data[DIM_W-1:0];
      end else begin
        return;
      end
      reload_slots();
    endfunction

    // Works out the verdict and slot of one accepted frame size.
    function void note_frame(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h);
      int unsigned key_old;
      int unsigned s;
      int unsigned hit;
      int unsigned victim;
      int unsigned lowest;
      bit          found;
      decision_t   d;
      key_old = score[0];
      found   = 1'b0;
      hit     = 0;
      for (int i = 0; i < SLOTS; i++) begin
        if (width[i] == w && height[i] == h) begin
          found = 1'b1;
          hit   = i;
        end
      end
      if (found) begin
        s = score[hit] + ((hit == last_hit) ? REPEAT_BONUS : SINGLE_BONUS);
        if (s >= SCORE_MAX) begin
          s = SCORE_MAX;
          saturated++;
        end
        score[hit] = s;
        last_hit   = hit;
        if (hit == 0) begin
          d.verdict = VERDICT_SAME;
        end else if (s >= key_old) begin
          d.verdict = VERDICT_KEY_ERR;
        end else begin
          d.verdict = VERDICT_DIFFERS;
        end
      end else begin
        lowest = score[0];
        victim = 0;
        for (int i = 0; i < SLOTS; i++) begin
          if (score[i] < lowest) begin
            lowest = score[i];
            victim = i;
          end
        end
        width[victim]  = w;
        height[victim] = h;
        score[victim]  = size_score(w, h);
        last_hit       = victim;
        d.verdict      = VERDICT_DIFFERS;
        misses++;
      end
      d.slot = last_hit[SLOT_OUT_W-1:0];
      decision_q.push_back(d);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 100) begin
        $display("%0t ns MISMATCH: %s", $time, msg);
      end
    endtask

    task check_beat(logic [1:0] verdict, logic [SLOT_OUT_W-1:0] slot);
      decision_t d;
      if (decision_q.size() == 0) begin
        report($sformatf("verdict %0d slot %0d with nothing outstanding", verdict, slot));
        return;
      end
      d = decision_q.pop_front();
      checked++;
      n_verdict[d.verdict]++;
      if (verdict !== d.verdict) begin
        report($sformatf("verdict %0d, expected %s", verdict, d.verdict.name()));
      end
      if (slot !== d.slot) begin
        report($sformatf("slot %0d, expected %0d", slot, d.slot));
      end
    endtask
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  rcsf_in_if  in_chan();
  rcsf_out_if out_chan();

  resolution_change_score_filter_top u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_chan    (in_chan),
    .out_chan   (out_chan),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  slot_table_board board = new();

  int unsigned      src_idle_pct;
  int unsigned      snk_stall_pct;
  int unsigned      hold_left;
  bit               burst_on;
  logic [DIM_W-1:0] prev_w;
  logic [DIM_W-1:0] prev_h;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // All beats and register writes are observed here, at the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we) begin
        board.write_reg(cfg_idx, cfg_data);
      end
      if (in_chan.valid && in_chan.ready) begin
        board.note_frame(in_chan.frame_width, in_chan.frame_height);
      end
      if (out_chan.valid && out_chan.ready) begin
        board.check_beat(out_chan.verdict, out_chan.slot);
      end
    end
  end

  // Receiver: a long hold-off takes precedence over the random stall rate.
  initial begin
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        out_chan.ready = 1'b0;
        hold_left--;
      end else if (burst_on) begin
        out_chan.ready = 1'b1;
      end else begin
        out_chan.ready = ($urandom_range(99) >= snk_stall_pct);
      end
    end
  end

  task automatic send_frame(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
    while (!burst_on && $urandom_range(99) < src_idle_pct) begin
      in_chan.valid = 1'b0;
      @(negedge clk_i);
    end
    in_chan.valid        = 1'b1;
    in_chan.frame_width  = w;
    in_chan.frame_height = h;
    prev_w               = w;
    prev_h               = h;
    do @(posedge clk_i); while (!in_chan.ready);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_chan.valid = 1'b0;
    while (board.decision_q.size() != 0) @(negedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = data;
    @(negedge clk_i);
    cfg_we = 1'b0;
  endtask

  task automatic load_key(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
    wait_drained();
    write_cfg(REG_KEY_WIDTH, w);
    write_cfg(REG_KEY_HEIGHT, h);
    @(negedge clk_i);
  endtask

  // Mostly sizes already in the table or repeats, so that scores climb and collide.
  function automatic void pick_frame(output logic [DIM_W-1:0] w, output logic [DIM_W-1:0] h);
    int unsigned r;
    int unsigned k;
    r = $urandom_range(99);
    if (r < 35) begin
      k = $urandom_range(SLOTS - 1);
      w = board.width[k];
      h = board.height[k];
    end else if (r < 55) begin
      w = prev_w;
      h = prev_h;
    end else if (r < 70) begin
      k = $urandom_range(KNOWN_N - 1);
      w = DIM_W'(KNOWN_SIZE[k][0]);
      h = DIM_W'(KNOWN_SIZE[k][1]);
    end else if (r < 77) begin
      w = board.key_w;
      h = board.key_h;
    end else if (r < 82) begin
      w = '0;
      h = '0;
    end else begin
      w = DIM_W'($urandom_range(4095));
      h = DIM_W'($urandom_range(4095));
    end
  endfunction

  task automatic run_frames(input int unsigned count, input int unsigned src_pct,
                            input int unsigned snk_pct);
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
    int unsigned      burst_left;
    src_idle_pct  = src_pct;
    snk_stall_pct = snk_pct;
    burst_left    = 0;
    repeat (count) begin
      if (burst_left == 0 && $urandom_range(29) == 0) begin
        burst_left = $urandom_range(24, 8);
      end
      burst_on = (burst_left != 0);
      if (burst_left != 0) begin
        burst_left--;
      end
      pick_frame(w, h);
      send_frame(w, h);
    end
    burst_on = 1'b0;
  endtask

  initial begin
    rst_ni               = 1'b0;
    cfg_we               = 1'b0;
    cfg_idx              = REG_KEY_WIDTH;
    cfg_data             = '0;
    in_chan.valid        = 1'b0;
    in_chan.frame_width  = '0;
    in_chan.frame_height = '0;
    prev_w               = '0;
    prev_h               = '0;
    src_idle_pct         = 0;
    snk_stall_pct        = 0;
    hold_left            = 0;
    burst_on             = 1'b0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset key 720 by 576: repeats up to saturation, cleared slots, misses, key error.
    send_frame(12'd720, 12'd576);
    send_frame(12'd720, 12'd576);
    send_frame(12'd720, 12'd576);
    send_frame(12'd0, 12'd0);
    send_frame(12'd0, 12'd0);
    send_frame(12'd352, 12'd576);
    send_frame(12'd4095, 12'd4095);
    send_frame(12'd0, 12'd4095);
    send_frame(12'd4095, 12'd0);
    send_frame(12'd1920, 12'd1088);
    send_frame(12'd1920, 12'd1088);
    send_frame(12'd1920, 12'd1088);
    send_frame(12'd720, 12'd480);
    send_frame(12'd640, 12'd480);
    send_frame(12'd352, 12'd576);

    // A 0 by 0 key scores zero, so a miss may take over slot zero itself.
    load_key(12'd0, 12'd0);
    send_frame(12'd0, 12'd0);
    send_frame(12'd4095, 12'd4095);
    send_frame(12'd4095, 12'd4095);
    send_frame(12'd0, 12'd0);

    // Writes to unused indexes must leave the table alone.
    wait_drained();
    write_cfg(REG_UNUSED_HIGH, 12'hABC);
    write_cfg(REG_UNUSED_LOW, 12'h543);
    @(negedge clk_i);
    send_frame(12'd4095, 12'd4095);

    load_key(12'd1920, 12'd1088);
    run_frames(450, 0, 0);
    load_key(DIM_W'($urandom_range(4095)), DIM_W'($urandom_range(4095)));
    run_frames(450, 86, 0);
    load_key(12'd4095, 12'd0);
    run_frames(450, 0, 86);
    load_key(12'd0, 12'd4095);
    run_frames(450, 16, 16);

    // Receiver holds off while the sender keeps offering, then the sender waits it out.
    load_key(12'd352, 12'd576);
    hold_left = 400;
    run_frames(40, 0, 0);
    wait_drained();
    run_frames(60, 16, 16);

    wait_drained();
    repeat (2 * LATENCY) @(negedge clk_i);
    if (board.decision_q.size() != 0) begin
      board.report($sformatf("%0d results never arrived", board.decision_q.size()));
    end
    $display("Checked %0d frame sizes over %0d table loads: %0d same, %0d differs, %0d key error.",
             board.checked, board.reloads, board.n_verdict[VERDICT_SAME],
             board.n_verdict[VERDICT_DIFFERS], board.n_verdict[VERDICT_KEY_ERR]);
    $display("Slot replacements: %0d, saturated scores: %0d, mismatches: %0d.",
             board.misses, board.saturated, board.errors);
    if (board.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timeout with %0d results outstanding.", board.decision_q.size());
    $display("tb: failure");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/rcsf_pkg.sv
rtl/rcsf_in_if.sv
rtl/rcsf_out_if.sv
rtl/rcsf_cell.sv
rtl/resolution_change_score_filter_top.sv
tb/tb_top.sv
